// ===== hw/rtl/command_frame_session_parser_core_defines.svh =====
// Assertion macros for the command frame session parser.
// Included by the top level; no other dependencies.
`ifndef COMMAND_FRAME_SESSION_PARSER_CORE_DEFINES_SVH
`define COMMAND_FRAME_SESSION_PARSER_CORE_DEFINES_SVH

// Immediate implication checked at every clock edge outside reset.
`define CFSP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cfsp check failed");

// Next-cycle implication checked outside reset.
`define CFSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cfsp check failed");

`endif

// ===== hw/rtl/cfsp_pkg.sv =====
// Shared types, constants and CRC helpers of the command frame session parser.
// No dependencies.
package cfsp_pkg;

    localparam logic [63:0] MAGIC      = 64'h31444D434D43504E; // "NPCMCMD1", first byte low
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
    localparam logic [31:0] CRC_XOROUT = 32'hFFFFFFFF;
    localparam logic [7:0]  VERSION    = 8'd1;
    localparam logic [7:0]  FRAME_LEN  = 8'd20;

    // Byte positions after the magic, counted from byte 8.
    localparam logic [3:0] IDX_VER      = 4'd0;
    localparam logic [3:0] IDX_CMD      = 4'd1;
    localparam logic [3:0] IDX_LEN_LO   = 4'd2;
    localparam logic [3:0] IDX_LEN_HI   = 4'd3;
    localparam logic [3:0] IDX_SESS_END = 4'd7;
    localparam logic [3:0] IDX_LAST     = 4'd11;

    localparam logic [1:0] CMD_INFO  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    localparam logic [1:0] KIND_HELLO   = 2'd0;
    localparam logic [1:0] KIND_STARTED = 2'd1;
    localparam logic [1:0] KIND_STOPPED = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    typedef struct packed {
        logic [1:0]  code;
        logic [31:0] sess;
    } t_cmd;

    typedef struct packed {
        logic        restart_sequence;
        logic        clear_counters;
        logic        stop_capture;
        logic        start_capture;
        logic [31:0] reply_session;
        logic [1:0]  reply_kind;
    } t_reply;

    typedef struct packed {
        logic armed;
        logic streaming;
    } t_status;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic logic [31:0] crc_magic();
        logic [31:0] r;
        r = CRC_INIT;
        for (int k = 0; k < 8; k++) begin
            r = crc_byte(r, MAGIC[8*k +: 8]);
        end
        return r;
    endfunction

    // CRC state after the eight magic bytes, fixed at elaboration.
    localparam logic [31:0] CRC_AFTER_MAGIC = crc_magic();

endpackage

// ===== hw/rtl/cfsp_front.sv =====
// Front end: magic hunt, header capture and byte-serial CRC check.
// Depends on cfsp_pkg.
module cfsp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    output logic              o_push,
    output cfsp_pkg::t_cmd    o_cmd
);
    localparam logic PH_HUNT = 1'b0;
    localparam logic PH_BODY = 1'b1;

    logic        r_phase, n_phase;
    logic [2:0]  r_cnt, n_cnt;
    logic [55:0] r_hunt, n_hunt;
    logic [3:0]  r_idx, n_idx;
    logic [31:0] r_crc, n_crc;
    logic        r_ok, n_ok;
    logic [7:0]  r_cmd, n_cmd;
    logic [31:0] r_sess, n_sess;
    logic [23:0] r_rxw, n_rxw;
    logic        cmd_known;
    logic        crc_match;

    assign cmd_known = (r_cmd[7:2] == 6'd0) && (r_cmd[1:0] != 2'd0);
    assign crc_match = ((r_crc ^ cfsp_pkg::CRC_XOROUT) == {i_byte, r_rxw});

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_hunt  = r_hunt;
        n_idx   = r_idx;
        n_crc   = r_crc;
        n_ok    = r_ok;
        n_cmd   = r_cmd;
        n_sess  = r_sess;
        n_rxw   = r_rxw;
        o_push  = 1'b0;
        if (i_accept) begin
            if (r_phase == PH_HUNT) begin
                n_hunt = {i_byte, r_hunt[55:8]};
                if (r_cnt != 3'd7) begin
                    n_cnt = r_cnt + 3'd1;
                end else if ({i_byte, r_hunt} == cfsp_pkg::MAGIC) begin
                    n_phase = PH_BODY;
                    n_idx   = 4'd0;
                    n_cnt   = 3'd0;
                    n_crc   = cfsp_pkg::CRC_AFTER_MAGIC;
                end
            end else begin
                if (r_idx <= cfsp_pkg::IDX_SESS_END) begin
                    n_crc = cfsp_pkg::crc_byte(r_crc, i_byte);
                end
                if (r_idx == cfsp_pkg::IDX_VER) begin
                    n_ok = (i_byte == cfsp_pkg::VERSION);
                end else if (r_idx == cfsp_pkg::IDX_CMD) begin
                    n_cmd = i_byte;
                end else if (r_idx == cfsp_pkg::IDX_LEN_LO) begin
                    n_ok = r_ok && (i_byte == cfsp_pkg::FRAME_LEN);
                end else if (r_idx == cfsp_pkg::IDX_LEN_HI) begin
                    n_ok = r_ok && (i_byte == 8'd0);
                end else if (r_idx <= cfsp_pkg::IDX_SESS_END) begin
                    n_sess = {i_byte, r_sess[31:8]};
                end else if (r_idx != cfsp_pkg::IDX_LAST) begin
                    n_rxw = {i_byte, r_rxw[23:8]};
                end
                if (r_idx == cfsp_pkg::IDX_LAST) begin
                    o_push  = r_ok && cmd_known && crc_match;
                    n_phase = PH_HUNT;
                    n_cnt   = 3'd0;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
        end
    end

    assign o_cmd.code = r_cmd[1:0];
    assign o_cmd.sess = r_sess;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_cnt   <= 3'd0;
            r_idx   <= 4'd0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
        end
        r_hunt <= n_hunt;
        r_crc  <= n_crc;
        r_ok   <= n_ok;
        r_cmd  <= n_cmd;
        r_sess <= n_sess;
        r_rxw  <= n_rxw;
    end
endmodule

// ===== hw/rtl/cfsp_fifo.sv =====
// Two-entry command queue between front and back ends.
// Depends on cfsp_pkg.
module cfsp_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cfsp_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output cfsp_pkg::t_cmd o_cmd
);
    cfsp_pkg::t_cmd r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

// ===== hw/rtl/cfsp_back.sv =====
// Back end: session state update and registered reply output.
// Depends on cfsp_pkg.
module cfsp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  cfsp_pkg::t_cmd    i_cmd,
    output logic              o_pop,
    input  logic              i_take,
    output logic              o_valid,
    output cfsp_pkg::t_reply  o_reply,
    output cfsp_pkg::t_status o_status
);
    logic             r_armed, n_armed;
    logic             r_stream, n_stream;
    logic [31:0]      r_sess, n_sess;
    logic             r_valid;
    cfsp_pkg::t_reply r_reply, n_reply;
    logic             emit;

    assign o_pop = !i_empty && (!r_valid || i_take);

    always_comb begin
        n_armed  = r_armed;
        n_stream = r_stream;
        n_sess   = r_sess;
        n_reply  = '0;
        emit     = 1'b0;
        unique case (i_cmd.code)
            cfsp_pkg::CMD_INFO: begin
                n_sess   = i_cmd.sess;
                n_armed  = 1'b1;
                n_stream = 1'b0;
                emit     = 1'b1;
                n_reply.reply_kind       = cfsp_pkg::KIND_HELLO;
                n_reply.stop_capture     = 1'b1;
                n_reply.clear_counters   = 1'b1;
                n_reply.restart_sequence = 1'b1;
            end
            cfsp_pkg::CMD_START: begin
                emit = 1'b1;
                n_reply.restart_sequence = 1'b1;
                if (!r_armed || (i_cmd.sess != r_sess)) begin
                    n_sess   = i_cmd.sess;
                    n_armed  = 1'b0;
                    n_stream = 1'b0;
                    n_reply.reply_kind   = cfsp_pkg::KIND_ERROR;
                    n_reply.stop_capture = 1'b1;
                end else begin
                    n_stream = 1'b1;
                    n_reply.reply_kind    = cfsp_pkg::KIND_STARTED;
                    n_reply.start_capture = 1'b1;
                end
            end
            cfsp_pkg::CMD_STOP: begin
                if (i_cmd.sess == r_sess) begin
                    n_stream = 1'b0;
                    emit     = 1'b1;
                    n_reply.reply_kind   = cfsp_pkg::KIND_STOPPED;
                    n_reply.stop_capture = 1'b1;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        n_reply.reply_session = n_sess;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed  <= 1'b0;
            r_stream <= 1'b0;
            r_sess   <= 32'd0;
            r_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_armed  <= n_armed;
                r_stream <= n_stream;
                r_sess   <= n_sess;
            end
            if (o_pop && emit) begin
                r_valid <= 1'b1;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
        end
        if (o_pop && emit) begin
            r_reply <= n_reply;
        end
    end

    assign o_valid            = r_valid;
    assign o_reply            = r_reply;
    assign o_status.armed     = r_armed;
    assign o_status.streaming = r_stream;
endmodule

// ===== hw/rtl/command_frame_session_parser_core.sv =====
// A frame's last byte pushes its command into the queue; the back end then pops it and
// registers the reply once its output register is free or being taken.
// Throughput: one received byte per cycle; the CRC advances one byte per cycle and the
// input stalls only while the two-entry command queue is full.
// Reset (synchronous, active low) empties the window and queue, drops any pending
// reply, and clears the armed and streaming flags and the current session.
`include "command_frame_session_parser_core_defines.svh"
module command_frame_session_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave side: one received byte per request.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    // Master side: one reply per request.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // [1:0] reply_kind, [33:2] reply_session,
                                     // [34] start_capture, [35] stop_capture,
                                     // [36] clear_counters, [37] restart_sequence, rest zero
);
    logic              accept;
    logic              push;
    logic              pop;
    logic              full;
    logic              empty;
    cfsp_pkg::t_cmd    front_cmd;
    cfsp_pkg::t_cmd    queue_cmd;
    cfsp_pkg::t_reply  reply;
    cfsp_pkg::t_status status;

    // The front end never stalls mid-frame except when the queue is full, since
    // at most one command is produced per byte.
    assign o_s_tready = !full;
    assign accept     = i_s_tvalid && o_s_tready;

    cfsp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_tdata),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    cfsp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (queue_cmd)
    );

    // The back end holds its reply in an output register and keeps draining
    // the queue whenever that register is free or being taken.
    cfsp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_cmd    (queue_cmd),
        .o_pop    (pop),
        .i_take   (o_m_tvalid && i_m_tready),
        .o_valid  (o_m_tvalid),
        .o_reply  (reply),
        .o_status (status)
    );

    assign o_m_tdata = {2'b00, reply};

    // Streaming can only have been entered from the armed state.
    `CFSP_ASSERT_IMP(a_stream_armed, status.streaming, status.armed)
    // No reply asks to start and stop capture at once.
    `CFSP_ASSERT_IMP(a_start_stop_excl, o_m_tvalid, !(reply.start_capture && reply.stop_capture))
    // A hello reply always clears counters and restarts the sequence.
    `CFSP_ASSERT_IMP(a_hello_actions, o_m_tvalid && (reply.reply_kind == cfsp_pkg::KIND_HELLO),
        reply.clear_counters && reply.restart_sequence)
    // A command pushed into an empty queue while no reply is held is consumed on the next cycle.
    `CFSP_ASSERT_NEXT(a_queue_drain, push && empty && !o_m_tvalid, pop)
endmodule
